### rtl/core/lca_pkg.sv
// ----------------------------------------------------------------------------
// LCA engine package
// Shared constants, request and response types, and a jump table address helper.
// ----------------------------------------------------------------------------
package lca_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int JUMP_LEVELS = 10;
   localparam int NODE_W      = 10;
   localparam int DEPTH_W     = 10;
   localparam int PATH_W      = 11;
   localparam int LVL_W       = $clog2(JUMP_LEVELS + 1);
   localparam int JUMP_DEPTH  = MAX_NODES * JUMP_LEVELS;
   localparam int JADDR_W     = $clog2(JUMP_DEPTH);
   localparam int NINFO_W     = DEPTH_W + 1;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [PATH_W-1:0]  path_type;
   typedef logic [LVL_W-1:0]   lvl_type;
   typedef logic [JADDR_W-1:0] jaddr_type;
   typedef logic [1:0]         status_type;

   localparam status_type ST_OK           = 2'd0;
   localparam status_type ST_BAD_NODE     = 2'd1;
   localparam status_type ST_NOT_ATTACHED = 2'd2;

   localparam logic KIND_ATTACH = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic     kind;
      node_type node_a;
      node_type node_b;
   } req_type;

   typedef struct packed {
      node_type   common_ancestor;
      path_type   path_length;
      depth_type  node_depth;
      status_type status;
   } rsp_type;

   function automatic jaddr_type jump_addr(input node_type node, input lvl_type lvl);
      jump_addr = JADDR_W'(node) * JADDR_W'(JUMP_LEVELS) + JADDR_W'(lvl);
   endfunction

endpackage

### rtl/core/lca_ram.sv
// ----------------------------------------------------------------------------
// LCA generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/lca_binary_lifting_engine.sv
// The time an attach or query takes is set by the reads of the jump table,
// which has a single read port. One request is in work at a time; the next
// is taken as soon as the result is in the output register. After reset all
// MAX_NODES entries of the node table are cleared, and no request is accepted
// during the clear.
// ----------------------------------------------------------------------------
// LCA binary lifting engine
// Attaches nodes to a tree and answers lowest common ancestor queries.
// ----------------------------------------------------------------------------
module lca_binary_lifting_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  lca_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output lca_pkg::rsp_type rsp_data
);
   import lca_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_CHECK, S_FILL_RD, S_FILL_WR,
      S_LIFT_RD, S_LIFT_WR, S_MEET, S_PAIR_RX, S_PAIR_RY, S_PAIR_CMP,
      S_FIN_RD, S_FIN_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   node_type  clr_ff, clr_in;
   logic      kind_ff, kind_in;
   node_type  a_ff, a_in, b_ff, b_in, x_ff, x_in, y_ff, y_in, jx_ff, jx_in;
   depth_type da_ff, da_in, db_ff, db_in, dy_ff, dy_in, diff_ff, diff_in;
   depth_type dcur_ff, dcur_in, res_dep_ff, res_dep_in;
   node_type  res_anc_ff, res_anc_in;
   status_type res_st_ff, res_st_in;
   lvl_type   lvl_ff, lvl_in;
   logic      zero_ff, zero_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic               nwr_en;
   node_type           nwr_addr, nrd_addr;
   logic [NINFO_W-1:0] nwr_data, nrd_data;
   logic               jwr_en;
   jaddr_type          jwr_addr, jrd_addr;
   node_type           jwr_data, jrd_data, jval;
   logic               att_rd;
   depth_type          dep_rd;
   path_type           len;

   lca_ram #(.WIDTH(NINFO_W), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(nwr_en), .wr_addr(nwr_addr), .wr_data(nwr_data),
      .rd_addr(nrd_addr), .rd_data(nrd_data)
   );

   lca_ram #(.WIDTH(NODE_W), .DEPTH(JUMP_DEPTH)) u_jump_ram (
      .clock(clock), .wr_en(jwr_en), .wr_addr(jwr_addr), .wr_data(jwr_data),
      .rd_addr(jrd_addr), .rd_data(jrd_data)
   );

   assign att_rd    = nrd_data[NINFO_W-1];
   assign dep_rd    = nrd_data[DEPTH_W-1:0];
   assign jval      = zero_ff ? '0 : jrd_data;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign len       = PATH_W'(da_ff) + PATH_W'(db_ff) - (PATH_W'(res_dep_ff) << 1);

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; kind_in = kind_ff;
      a_in = a_ff; b_in = b_ff; x_in = x_ff; y_in = y_ff; jx_in = jx_ff;
      da_in = da_ff; db_in = db_ff; dy_in = dy_ff; diff_in = diff_ff;
      dcur_in = dcur_ff; res_dep_in = res_dep_ff; res_anc_in = res_anc_ff;
      res_st_in = res_st_ff; lvl_in = lvl_ff; zero_in = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      nwr_en = 1'b0; nwr_addr = clr_ff; nwr_data = '0; nrd_addr = a_ff;
      jwr_en = 1'b0; jwr_addr = jump_addr(a_ff, lvl_ff); jwr_data = x_ff;
      jrd_addr = jump_addr(x_ff, lvl_ff);
      case (state_ff)
         S_CLEAR: begin
            nwr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == node_type'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.kind;
               a_in     = req_data.node_a;
               b_in     = req_data.node_b;
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            nrd_addr = a_ff;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            nrd_addr = b_ff;
            da_in    = dep_rd;
            zero_in  = att_rd;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            db_in      = dep_rd;
            res_anc_in = '0;
            res_dep_in = '0;
            state_in   = S_DONE;
            if (kind_ff == KIND_ATTACH) begin
               if (a_ff == '0 || zero_ff) begin
                  res_st_in = ST_BAD_NODE;
               end else if (b_ff != '0 && !att_rd) begin
                  res_st_in = ST_NOT_ATTACHED;
               end else begin
                  nwr_en   = 1'b1;
                  nwr_addr = a_ff;
                  nwr_data = {1'b1, dep_rd + 1'b1};
                  jwr_en   = 1'b1;
                  jwr_addr = jump_addr(a_ff, '0);
                  jwr_data = b_ff;
                  dcur_in  = dep_rd + 1'b1;
                  x_in     = b_ff;
                  lvl_in   = lvl_type'(1);
                  state_in = S_FILL_RD;
               end
            end else begin
               if (a_ff == '0 || b_ff == '0) begin
                  res_st_in = ST_BAD_NODE;
               end else if (!zero_ff || !att_rd) begin
                  res_st_in = ST_NOT_ATTACHED;
               end else begin
                  if (da_ff < dep_rd) begin
                     x_in = b_ff; y_in = a_ff; dy_in = da_ff; diff_in = dep_rd - da_ff;
                  end else begin
                     x_in = a_ff; y_in = b_ff; dy_in = dep_rd; diff_in = da_ff - dep_rd;
                  end
                  lvl_in   = lvl_type'(JUMP_LEVELS - 1);
                  state_in = S_LIFT_RD;
               end
            end
         end
         S_FILL_RD: begin
            if (lvl_ff == lvl_type'(JUMP_LEVELS)) begin
               res_st_in  = ST_OK;
               res_anc_in = b_ff;
               res_dep_in = dcur_ff;
               state_in   = S_DONE;
            end else begin
               jrd_addr = jump_addr(x_ff, lvl_ff - 1'b1);
               zero_in  = (x_ff == '0);
               state_in = S_FILL_WR;
            end
         end
         S_FILL_WR: begin
            jwr_en   = 1'b1;
            jwr_addr = jump_addr(a_ff, lvl_ff);
            jwr_data = jval;
            x_in     = jval;
            lvl_in   = lvl_ff + 1'b1;
            state_in = S_FILL_RD;
         end
         S_LIFT_RD: begin
            if (((diff_ff >> lvl_ff) & depth_type'(1)) != '0) begin
               jrd_addr = jump_addr(x_ff, lvl_ff);
               zero_in  = (x_ff == '0);
               state_in = S_LIFT_WR;
            end else if (lvl_ff == '0) begin
               state_in = S_MEET;
            end else begin
               lvl_in = lvl_ff - 1'b1;
            end
         end
         S_LIFT_WR: begin
            x_in = jval;
            if (lvl_ff == '0) begin
               state_in = S_MEET;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               state_in = S_LIFT_RD;
            end
         end
         S_MEET: begin
            if (x_ff == y_ff) begin
               res_st_in  = ST_OK;
               res_anc_in = x_ff;
               res_dep_in = dy_ff;
               state_in   = S_DONE;
            end else begin
               dcur_in  = dy_ff;
               lvl_in   = lvl_type'(JUMP_LEVELS - 1);
               state_in = S_PAIR_RX;
            end
         end
         S_PAIR_RX: begin
            jrd_addr = jump_addr(x_ff, lvl_ff);
            zero_in  = (x_ff == '0);
            state_in = S_PAIR_RY;
         end
         S_PAIR_RY: begin
            jx_in    = jval;
            jrd_addr = jump_addr(y_ff, lvl_ff);
            zero_in  = (y_ff == '0);
            state_in = S_PAIR_CMP;
         end
         S_PAIR_CMP: begin
            if (jx_ff != jval) begin
               x_in    = jx_ff;
               y_in    = jval;
               dcur_in = dcur_ff - (depth_type'(1) << lvl_ff);
            end
            if (lvl_ff == '0) begin
               state_in = S_FIN_RD;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               state_in = S_PAIR_RX;
            end
         end
         S_FIN_RD: begin
            jrd_addr = jump_addr(x_ff, '0);
            zero_in  = (x_ff == '0);
            state_in = S_FIN_WR;
         end
         S_FIN_WR: begin
            res_st_in  = ST_OK;
            res_anc_in = jval;
            res_dep_in = dcur_ff - 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.common_ancestor = res_anc_ff;
               rsp_data_in.node_depth      = res_dep_ff;
               rsp_data_in.status          = res_st_ff;
               rsp_data_in.path_length     =
                  (kind_ff == KIND_QUERY && res_st_ff == ST_OK) ? len : '0;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in; a_ff <= a_in; b_ff <= b_in; x_ff <= x_in; y_ff <= y_in;
      jx_ff <= jx_in; da_ff <= da_in; db_ff <= db_in; dy_ff <= dy_in;
      diff_ff <= diff_in; dcur_ff <= dcur_in; res_dep_ff <= res_dep_in;
      res_anc_ff <= res_anc_in; res_st_ff <= res_st_in; lvl_ff <= lvl_in;
      zero_ff <= zero_in; rsp_data_ff <= rsp_data_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_RD_A)
      else $error("accepted request did not start a lookup");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("request taken during table clear");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.common_ancestor == '0 && rsp_data.node_depth == '0 &&
         rsp_data.path_length == '0)
      else $error("error response carries data");

   a_write_only_on_attach: assert property (@(posedge clock) disable iff (reset)
      jwr_en |-> kind_ff == KIND_ATTACH)
      else $error("jump table written during a query");

endmodule
